// File: rtl/core/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared widths, defaults, codes and types of the page table translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned PAGE_NUM_W = 8;
  localparam int unsigned TAG_W     = 8;
  localparam int unsigned FRAME_W   = 8;
  localparam int unsigned PHYS_W    = 16;
  localparam int unsigned OUTCOME_W = 2;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned NFF_W     = 9;

  localparam int unsigned TLB_ENTRIES_DEF = 16;
  localparam int unsigned PAGE_COUNT_DEF  = 256;
  localparam int unsigned PAGE_BYTES_DEF  = 256;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_TLB_HIT = 2'd0,
    OUT_PT_HIT  = 2'd1,
    OUT_FAULT   = 2'd2
  } outcome_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_TABLE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               en;
    logic [TAG_W-1:0]   tag;
    logic [FRAME_W-1:0] frame;
  } tlb_fill_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
  } tlb_look_t;

endpackage

// File: rtl/core/tlbpt_ram.sv
// ----------------------------------------------------------------------------
// tlbpt_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/tlbpt_tlb.sv
// ----------------------------------------------------------------------------
// tlbpt_tlb
// TLB entry store with one shared tag comparator and FIFO refill pointer.
// ----------------------------------------------------------------------------
module tlbpt_tlb #(
  parameter int unsigned TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
  localparam int unsigned IDX_W      = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [IDX_W-1:0]           idx_i,
  input  logic [tlbpt_pkg::TAG_W-1:0] tag_i,
  input  tlbpt_pkg::tlb_fill_t       fill_i,
  output tlbpt_pkg::tlb_look_t       look_o
);
  import tlbpt_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);

  logic [TAG_W-1:0]   tag_q   [TLB_ENTRIES];
  logic [FRAME_W-1:0] frame_q [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] valid_q;
  logic [IDX_W-1:0]   ptr_q, ptr_d;

  // shared comparator, one entry per cycle
  always_comb begin
    look_o.hit   = valid_q[idx_i] && (tag_q[idx_i] == tag_i);
    look_o.frame = frame_q[idx_i];
  end

  always_comb begin
    ptr_d = ptr_q;
    if (fill_i.en) begin
      ptr_d = (ptr_q == LAST_IDX) ? '0 : ptr_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
    end else begin
      ptr_q <= ptr_d;
      if (fill_i.en) begin
        valid_q[ptr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_i.en) begin
      tag_q[ptr_q]   <= fill_i.tag;
      frame_q[ptr_q] <= fill_i.frame;
    end
  end

endmodule

// File: rtl/core/tlb_page_table_translator.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Address translator: TLB scan, page table lookup, in-order frame allocation.
//
//   channel   direction  handshake              payload
//   request   in         start_i / busy_o       logical_address_i
//   result    out        done_o (one cycle)     vpage_o, physical_address_o,
//                                               outcome_o, hits_so_far_o,
//                                               faults_so_far_o
//
// TLB hit: the scan stops at the hitting entry and goes on to the result state.
// TLB miss: the scan runs through every entry, then the page table, then the result.
// Entries are compared one per cycle by a single comparator, lowest first.
// After reset the page table is cleared entry by entry, with busy_o high.
// done_o lasts one cycle and cannot be held off; PAGE_BYTES and PAGE_COUNT
// must be powers of two, which the block itself does not check.
// ----------------------------------------------------------------------------
module tlb_page_table_translator #(
  parameter int unsigned TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int unsigned PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEF,
  parameter int unsigned PAGE_BYTES  = tlbpt_pkg::PAGE_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [tlbpt_pkg::ADDR_W-1:0]    logical_address_i,
  output logic                            done_o,
  output logic [tlbpt_pkg::PAGE_NUM_W-1:0] vpage_o,
  output logic [tlbpt_pkg::PHYS_W-1:0]    physical_address_o,
  output logic [tlbpt_pkg::OUTCOME_W-1:0] outcome_o,
  output logic [tlbpt_pkg::CNT_W-1:0]     hits_so_far_o,
  output logic [tlbpt_pkg::CNT_W-1:0]     faults_so_far_o
);
  import tlbpt_pkg::*;

  localparam int unsigned IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int unsigned PT_AW = $clog2(PAGE_COUNT);
  localparam int unsigned OFF_W = $clog2(PAGE_BYTES);
  localparam int unsigned RAM_W = FRAME_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);
  localparam logic [PT_AW-1:0] LAST_PAGE = PT_AW'(PAGE_COUNT - 1);

  state_e             state_q, state_d;
  logic [PT_AW-1:0]   page_q, page_d;
  logic [OFF_W-1:0]   off_q, off_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [PT_AW-1:0]   clr_q, clr_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  outcome_e           outcome_q, outcome_d;
  logic [CNT_W-1:0]   hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0]   fault_cnt_q, fault_cnt_d;
  logic [NFF_W-1:0]   nff_q, nff_d;

  logic               accept;
  logic [ADDR_W-1:0]  page_full;
  logic               ram_we, ram_re;
  logic [PT_AW-1:0]   ram_addr;
  logic [RAM_W-1:0]   ram_wdata, ram_rdata;
  tlb_fill_t          fill;
  tlb_look_t          look;

  assign accept    = start_i && !busy_o;
  assign page_full = logical_address_i >> OFF_W;

  tlbpt_tlb #(
    .TLB_ENTRIES(TLB_ENTRIES)
  ) u_tlb (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .idx_i (idx_q),
    .tag_i (TAG_W'(page_q)),
    .fill_i(fill),
    .look_o(look)
  );

  tlbpt_ram #(
    .WIDTH(RAM_W),
    .DEPTH(PAGE_COUNT)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST_PAGE) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (look.hit) begin
          state_d = ST_DONE;
        end else if (idx_q == LAST_IDX) begin
          state_d = ST_TABLE;
        end
      end
      ST_TABLE: state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    busy_o      = (state_q != ST_IDLE);
    done_o      = (state_q == ST_DONE);
    page_d      = page_q;
    off_d       = off_q;
    idx_d       = idx_q;
    clr_d       = clr_q;
    frame_d     = frame_q;
    outcome_d   = outcome_q;
    hit_cnt_d   = hit_cnt_q;
    fault_cnt_d = fault_cnt_q;
    nff_d       = nff_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = page_q;
    ram_wdata   = '0;
    fill        = '0;
    fill.tag    = TAG_W'(page_q);
    case (state_q)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + PT_AW'(1);
      end
      ST_IDLE: begin
        if (start_i) begin
          page_d = page_full[PT_AW-1:0];
          off_d  = logical_address_i[OFF_W-1:0];
          idx_d  = '0;
        end
      end
      ST_SCAN: begin
        if (look.hit) begin
          frame_d   = look.frame;
          outcome_d = OUT_TLB_HIT;
          if (hit_cnt_q != '1) hit_cnt_d = hit_cnt_q + CNT_W'(1);
        end else if (idx_q == LAST_IDX) begin
          ram_re = 1'b1;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_TABLE: begin
        fill.en = 1'b1;
        if (ram_rdata[FRAME_W]) begin
          frame_d    = ram_rdata[FRAME_W-1:0];
          outcome_d  = OUT_PT_HIT;
          fill.frame = ram_rdata[FRAME_W-1:0];
        end else begin
          frame_d    = nff_q[FRAME_W-1:0];
          outcome_d  = OUT_FAULT;
          fill.frame = nff_q[FRAME_W-1:0];
          nff_d      = nff_q + NFF_W'(1);
          if (fault_cnt_q != '1) fault_cnt_d = fault_cnt_q + CNT_W'(1);
          ram_we     = 1'b1;
          ram_wdata  = {1'b1, nff_q[FRAME_W-1:0]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      idx_q       <= '0;
      outcome_q   <= OUT_TLB_HIT;
      hit_cnt_q   <= '0;
      fault_cnt_q <= '0;
      nff_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      idx_q       <= idx_d;
      outcome_q   <= outcome_d;
      hit_cnt_q   <= hit_cnt_d;
      fault_cnt_q <= fault_cnt_d;
      nff_q       <= nff_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q  <= page_d;
    off_q   <= off_d;
    frame_q <= frame_d;
  end

  assign vpage_o            = PAGE_NUM_W'(page_q);
  assign physical_address_o = PHYS_W'({frame_q, off_q});
  assign outcome_o          = outcome_q;
  assign hits_so_far_o      = hit_cnt_q;
  assign faults_so_far_o    = fault_cnt_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accepted item did not raise busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_ram_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR || state_q == ST_TABLE))
    else $error("page table written outside clear or refill");

  a_fault_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && outcome_o == OUT_FAULT) |-> (fault_cnt_q != '0))
    else $error("fault reported with zero fault count");

  a_fill_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill.en |-> $past(state_q == ST_SCAN && !look.hit))
    else $error("tlb refill without a preceding miss");

endmodule
